// ===== hw/rtl/mtmbc_pkg.sv =====
`timescale 1ns / 1ps

package mtmbc_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int MAX_BLOCK_DEF = 64;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_GET    = 2'd1;
    localparam logic [1:0] CMD_SET    = 2'd2;

    typedef struct packed {
        logic take_byte;
        logic clr_len;
        logic emit_err;
        logic emit_look;
        logic look_hit;
        logic emit_byte;
        logic load_slot_i;
        logic load_slot_idx;
        logic clr_i;
        logic inc_i;
        logic inc_k;
        logic move_up;
        logic insert_prep;
        logic wr_store;
        logic wr_len;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic i_end;
        logic len_eq;
        logic byte_eq;
        logic k_last_in;
        logic k_last_get;
        logic over;
        logic idx_bad;
    } t_dp_stat;

endpackage

// ===== hw/rtl/mtmbc_if.sv =====
`timescale 1ns / 1ps

interface mtmbc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [3:0] entry_index;

    modport source (output valid, command, data_byte, last_byte, entry_index, input ready);
    modport sink   (input valid, command, data_byte, last_byte, entry_index, output ready);
endinterface

interface mtmbc_rsp_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic [3:0] hit_position;
    logic [6:0] block_length;
    logic [7:0] out_byte;
    logic       last_out;
    logic       error;

    modport source (output valid, hit, hit_position, block_length, out_byte, last_out, error,
                    input ready);
    modport sink   (input valid, hit, hit_position, block_length, out_byte, last_out, error,
                    output ready);
endinterface

// ===== hw/rtl/mtmbc_datapath.sv =====
`timescale 1ns / 1ps

module mtmbc_datapath #(
    parameter int ENTRIES   = mtmbc_pkg::ENTRIES_DEF,
    parameter int MAX_BLOCK = mtmbc_pkg::MAX_BLOCK_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mtmbc_pkg::t_dp_cmd  i_cmd,
    output mtmbc_pkg::t_dp_stat o_stat,
    input  logic [7:0]          i_data_byte,
    input  logic [3:0]          i_entry_index,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_hit,
    output logic [3:0]          o_hit_position,
    output logic [6:0]          o_block_length,
    output logic [7:0]          o_out_byte,
    output logic                o_last_out,
    output logic                o_error
);
    localparam int PW  = $clog2(ENTRIES);
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int LW  = $clog2(MAX_BLOCK + 2);
    localparam int BAW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int SD  = ENTRIES * MAX_BLOCK;
    localparam int SAW = $clog2(SD);
    localparam int IW  = CW + 4;

    logic [PW-1:0] r_om [ENTRIES];
    logic [PW-1:0] n_om [ENTRIES];
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_i;
    logic [LW-1:0] r_in_len;
    logic [LW-1:0] r_k;
    logic [PW-1:0] r_slot;

    logic [7:0]    r_store [SD];
    logic [LW-1:0] r_lens [ENTRIES];
    logic [7:0]    r_buf [MAX_BLOCK];
    logic [7:0]    r_store_q;
    logic [LW-1:0] r_len_q;
    logic [7:0]    r_buf_q;

    logic          r_out_valid;
    logic          r_hit;
    logic [3:0]    r_hit_position;
    logic [6:0]    r_block_length;
    logic [7:0]    r_out_byte;
    logic          r_last_out;
    logic          r_error;

    logic [SAW-1:0] store_addr;
    logic [PW-1:0]  om_addr;
    logic [PW-1:0]  om_rd;
    logic [PW-1:0]  mv_pos;
    logic [PW-1:0]  mv_tgt;
    logic           mv_en;
    logic           full;
    logic           out_free;
    logic           emit;

    assign full       = r_count >= CW'(ENTRIES);
    assign store_addr = SAW'(r_slot) * SAW'(MAX_BLOCK) + SAW'(r_k);
    assign out_free   = !r_out_valid || i_out_ready;
    assign emit       = i_cmd.emit_err || i_cmd.emit_look || i_cmd.emit_byte;

    always_comb begin
        if (i_cmd.load_slot_idx) begin
            om_addr = PW'(i_entry_index);
        end else if (i_cmd.insert_prep) begin
            om_addr = full ? PW'(ENTRIES - 1) : PW'(r_count);
        end else begin
            om_addr = PW'(r_i);
        end
    end

    assign om_rd  = r_om[om_addr];
    assign mv_pos = om_addr;
    assign mv_tgt = i_cmd.insert_prep ? PW'(r_count >> 1) : (PW'(r_i) >> 1);
    assign mv_en  = i_cmd.insert_prep || i_cmd.move_up;

    always_comb begin
        n_om[0] = (mv_en && mv_tgt == '0) ? om_rd : r_om[0];
        for (int k = 1; k < ENTRIES; k++) begin
            if (mv_en && PW'(k) == mv_tgt) begin
                n_om[k] = om_rd;
            end else if (mv_en && PW'(k) > mv_tgt && PW'(k) <= mv_pos) begin
                n_om[k] = r_om[k-1];
            end else begin
                n_om[k] = r_om[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ENTRIES; k++) begin
                r_om[k] <= PW'(k);
            end
            r_count     <= '0;
            r_in_len    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_om <= n_om;
            if (i_cmd.insert_prep && !full) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.clr_len) begin
                r_in_len <= '0;
            end else if (i_cmd.take_byte) begin
                r_in_len <= o_stat.over ? LW'(MAX_BLOCK + 1) : r_in_len + LW'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_slot_idx) begin
            r_i <= CW'(i_entry_index);
        end else if (i_cmd.clr_i) begin
            r_i <= '0;
        end else if (i_cmd.inc_i) begin
            r_i <= r_i + CW'(1);
        end
        if (i_cmd.load_slot_i || i_cmd.load_slot_idx || i_cmd.insert_prep) begin
            r_slot <= om_rd;
            r_k    <= '0;
        end else if (i_cmd.inc_k) begin
            r_k <= r_k + LW'(1);
        end
        if (emit) begin
            r_hit          <= i_cmd.emit_look && i_cmd.look_hit;
            r_hit_position <= (i_cmd.emit_look && i_cmd.look_hit) ? 4'(r_i) : 4'd0;
            r_block_length <= i_cmd.emit_byte ? 7'(r_len_q) : 7'd0;
            r_out_byte     <= i_cmd.emit_byte ? r_store_q : 8'd0;
            r_last_out     <= i_cmd.emit_byte ? o_stat.k_last_get : 1'b1;
            r_error        <= i_cmd.emit_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte && !o_stat.over) begin
            r_buf[BAW'(r_in_len)] <= i_data_byte;
        end
        r_buf_q <= r_buf[BAW'(r_k)];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_store) begin
            r_store[store_addr] <= r_buf_q;
        end
        r_store_q <= r_store[store_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_len) begin
            r_lens[r_slot] <= r_in_len;
        end
        r_len_q <= r_lens[r_slot];
    end

    assign o_stat.out_free   = out_free;
    assign o_stat.i_end      = r_i >= r_count;
    assign o_stat.len_eq     = r_len_q == r_in_len;
    assign o_stat.byte_eq    = r_store_q == r_buf_q;
    assign o_stat.k_last_in  = (r_k + LW'(1)) == r_in_len;
    assign o_stat.k_last_get = (r_k + LW'(1)) == r_len_q;
    assign o_stat.over       = r_in_len >= LW'(MAX_BLOCK);
    assign o_stat.idx_bad    = IW'(i_entry_index) >= IW'(r_count);

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit;
    assign o_hit_position = r_hit_position;
    assign o_block_length = r_block_length;
    assign o_out_byte     = r_out_byte;
    assign o_last_out     = r_last_out;
    assign o_error        = r_error;

endmodule

// ===== hw/rtl/mtmbc_ctrl.sv =====
`timescale 1ns / 1ps

module mtmbc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_command,
    input  logic                i_last_byte,
    input  mtmbc_pkg::t_dp_stat i_stat,
    output logic                o_in_ready,
    output mtmbc_pkg::t_dp_cmd  o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_SSLOT,
        S_SWAIT,
        S_SLEN,
        S_SCMP,
        S_SBW,
        S_INS,
        S_CWAIT,
        S_CWR,
        S_GWAIT,
        S_GOUT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE) && i_stat.out_free;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    case (i_command)
                        mtmbc_pkg::CMD_LOOKUP, mtmbc_pkg::CMD_SET: begin
                            o_cmd.take_byte = 1'b1;
                            if (i_last_byte) begin
                                if (i_stat.over) begin
                                    o_cmd.emit_err = 1'b1;
                                    o_cmd.clr_len  = 1'b1;
                                end else if (i_command == mtmbc_pkg::CMD_SET) begin
                                    n_state = S_INS;
                                end else begin
                                    o_cmd.clr_i = 1'b1;
                                    n_state     = S_SSLOT;
                                end
                            end
                        end
                        mtmbc_pkg::CMD_GET: begin
                            if (i_stat.idx_bad) begin
                                o_cmd.emit_err = 1'b1;
                            end else begin
                                o_cmd.load_slot_idx = 1'b1;
                                n_state             = S_GWAIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SSLOT: begin
                if (i_stat.i_end) begin
                    o_cmd.emit_look = 1'b1;
                    n_state         = S_INS;
                end else begin
                    o_cmd.load_slot_i = 1'b1;
                    n_state           = S_SWAIT;
                end
            end
            S_SWAIT: n_state = S_SLEN;
            S_SLEN: begin
                if (i_stat.len_eq) begin
                    n_state = S_SCMP;
                end else begin
                    o_cmd.inc_i = 1'b1;
                    n_state     = S_SSLOT;
                end
            end
            S_SCMP: begin
                if (!i_stat.byte_eq) begin
                    o_cmd.inc_i = 1'b1;
                    n_state     = S_SSLOT;
                end else if (i_stat.k_last_in) begin
                    o_cmd.emit_look = 1'b1;
                    o_cmd.look_hit  = 1'b1;
                    o_cmd.move_up   = 1'b1;
                    o_cmd.clr_len   = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.inc_k = 1'b1;
                    n_state     = S_SBW;
                end
            end
            S_SBW: n_state = S_SCMP;
            S_INS: begin
                o_cmd.insert_prep = 1'b1;
                n_state           = S_CWAIT;
            end
            S_CWAIT: n_state = S_CWR;
            S_CWR: begin
                o_cmd.wr_store = 1'b1;
                if (i_stat.k_last_in) begin
                    o_cmd.wr_len  = 1'b1;
                    o_cmd.clr_len = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.inc_k = 1'b1;
                    n_state     = S_CWAIT;
                end
            end
            S_GWAIT: n_state = S_GOUT;
            S_GOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_byte = 1'b1;
                    if (i_stat.k_last_get) begin
                        o_cmd.move_up = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        o_cmd.inc_k = 1'b1;
                        n_state     = S_GWAIT;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/move_to_middle_block_cache_unit.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Fields
// i_req    in   command, data_byte, last_byte, entry_index
// o_rsp    out  hit, hit_position, block_length, out_byte, last_out, error
//
// Non-final bytes are only buffered. Lookup end: the last byte is taken, then each position
// is searched in order, with bytes compared only at a position of matching length; a miss
// then inserts the block at the middle of the list and copies the block in.
// Set end: the block is inserted and copied in. Get: bytes return, held by output stalls.
// Reset is synchronous, active low; the block store needs no clearing pass.

module move_to_middle_block_cache_unit #(
    parameter int ENTRIES   = mtmbc_pkg::ENTRIES_DEF,
    parameter int MAX_BLOCK = mtmbc_pkg::MAX_BLOCK_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mtmbc_req_if.sink   i_req,
    mtmbc_rsp_if.source o_rsp
);
    mtmbc_pkg::t_dp_cmd  dp_cmd;
    mtmbc_pkg::t_dp_stat dp_stat;

    mtmbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_command  (i_req.command),
        .i_last_byte(i_req.last_byte),
        .i_stat     (dp_stat),
        .o_in_ready (i_req.ready),
        .o_cmd      (dp_cmd)
    );

    mtmbc_datapath #(
        .ENTRIES  (ENTRIES),
        .MAX_BLOCK(MAX_BLOCK)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_data_byte   (i_req.data_byte),
        .i_entry_index (i_req.entry_index),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_hit         (o_rsp.hit),
        .o_hit_position(o_rsp.hit_position),
        .o_block_length(o_rsp.block_length),
        .o_out_byte    (o_rsp.out_byte),
        .o_last_out    (o_rsp.last_out),
        .o_error       (o_rsp.error)
    );

endmodule

// ===== hw/rtl/mtmbc_checker.sv =====
`timescale 1ns / 1ps

module mtmbc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_ready,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic       i_rsp_hit,
    input logic [6:0] i_rsp_block_length,
    input logic [7:0] i_rsp_out_byte,
    input logic       i_rsp_last_out,
    input logic       i_rsp_error
);
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_out_byte)
            && $stable(i_rsp_last_out))
        else $error("result item changed while stalled");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_error |-> i_rsp_last_out && !i_rsp_hit
            && i_rsp_block_length == 7'd0)
        else $error("error item malformed");

    a_hit_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_hit |-> i_rsp_last_out && !i_rsp_error
            && i_rsp_out_byte == 8'd0)
        else $error("hit item malformed");

    a_get_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_last_out |-> !i_req_ready)
        else $error("input taken in the middle of a get");

endmodule

bind move_to_middle_block_cache_unit mtmbc_checker u_mtmbc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_hit         (o_rsp.hit),
    .i_rsp_block_length(o_rsp.block_length),
    .i_rsp_out_byte    (o_rsp.out_byte),
    .i_rsp_last_out    (o_rsp.last_out),
    .i_rsp_error       (o_rsp.error)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int NENT = mtmbc_pkg::ENTRIES_DEF;
    localparam int MAXB = mtmbc_pkg::MAX_BLOCK_DEF;
    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic       hit;
        logic [3:0] pos;
        logic [6:0] len;
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_rsp;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
        logic       last;
        logic [3:0] idx;
        logic       typed;
        logic       hit;
        logic [3:0] pos;
        logic       err;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mtmbc_req_if req ();
    mtmbc_rsp_if rsp ();

    move_to_middle_block_cache_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req.sink),
        .o_rsp  (rsp.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [3:0] order_q [NENT];
    int         n_valid;
    logic [7:0] store_q [NENT][MAXB];
    logic [6:0] len_q   [NENT];
    logic [7:0] stream_buf [MAXB];
    int         stream_len;

    t_rsp pending_rsp [$];
    t_row dir_tab [$];
    int   n_mismatch = 0;
    int   n_sent = 0;
    bit   calm = 0;

    logic [7:0] pool_data [24][MAXB];
    int         pool_len  [24];

    function automatic void promote(int p);
        logic [3:0] sv;
        int tg;
        if (p == 0) return;
        sv = order_q[p];
        tg = p >> 1;
        for (int k = p; k > tg; k--) order_q[k] = order_q[k-1];
        order_q[tg] = sv;
    endfunction

    function automatic void place_block();
        int ins;
        int st;
        logic [3:0] sv;
        ins = n_valid >> 1;
        if (n_valid >= NENT) st = NENT - 1;
        else begin
            st = n_valid;
            n_valid++;
        end
        sv = order_q[st];
        for (int k = st; k > ins; k--) order_q[k] = order_q[k-1];
        order_q[ins] = sv;
        for (int k = 0; k < stream_len; k++) store_q[sv][k] = stream_buf[k];
        len_q[sv] = 7'(stream_len);
    endfunction

    function automatic void cache_step(logic [1:0] cmd, logic [7:0] d, logic lst,
                                       logic [3:0] idx);
        t_rsp r;
        int fp;
        bit found;
        bit same;
        logic [3:0] sl;
        int ln;
        r = '0;
        if (cmd == mtmbc_pkg::CMD_LOOKUP || cmd == mtmbc_pkg::CMD_SET) begin
            if (stream_len < MAXB) begin
                stream_buf[stream_len] = d;
                stream_len++;
            end else stream_len = MAXB + 1;
            if (!lst) return;
            r.last = 1'b1;
            if (stream_len > MAXB) begin
                stream_len = 0;
                r.err = 1'b1;
                pending_rsp.push_back(r);
                return;
            end
            if (cmd == mtmbc_pkg::CMD_SET) begin
                place_block();
                stream_len = 0;
                return;
            end
            found = 0;
            fp = 0;
            for (int i = 0; i < n_valid && !found; i++) begin
                sl = order_q[i];
                same = (len_q[sl] == 7'(stream_len));
                for (int k = 0; k < stream_len && same; k++)
                    if (store_q[sl][k] != stream_buf[k]) same = 0;
                if (same) begin
                    found = 1;
                    fp = i;
                end
            end
            if (found) promote(fp);
            else place_block();
            stream_len = 0;
            r.hit = found;
            r.pos = 4'(fp);
            pending_rsp.push_back(r);
        end else if (cmd == mtmbc_pkg::CMD_GET) begin
            if (int'(idx) >= n_valid) begin
                r.last = 1'b1;
                r.err = 1'b1;
                pending_rsp.push_back(r);
                return;
            end
            sl = order_q[idx];
            ln = int'(len_q[sl]);
            for (int k = 0; k < ln; k++) begin
                r.len = 7'(ln);
                r.data = store_q[sl][k];
                r.last = (k + 1 == ln);
                pending_rsp.push_back(r);
            end
            promote(int'(idx));
        end
    endfunction

    task automatic send_item(logic [1:0] cmd, logic [7:0] d, logic lst, logic [3:0] idx,
                             bit typed = 0, t_rsp tr = '0);
        int g;
        int before_n;
        g = calm ? 0 : $urandom_range(0, 13);
        if (g > 0) begin
            req.valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        req.valid = 1'b1;
        req.command = cmd;
        req.data_byte = d;
        req.last_byte = lst;
        req.entry_index = idx;
        do @(posedge i_clk); while (!req.ready);
        before_n = pending_rsp.size();
        cache_step(cmd, d, lst, idx);
        if (typed) begin
            while (pending_rsp.size() > before_n) void'(pending_rsp.pop_back());
            pending_rsp.push_back(tr);
        end
        n_sent++;
        @(negedge i_clk);
        req.valid = 1'b0;
    endtask

    task automatic send_block(logic [1:0] cmd, int p);
        logic [1:0] c;
        for (int k = 0; k < pool_len[p]; k++) begin
            c = cmd;
            if (k + 1 < pool_len[p] && $urandom_range(0, 9) == 0)
                c = (cmd == mtmbc_pkg::CMD_SET) ? mtmbc_pkg::CMD_LOOKUP : mtmbc_pkg::CMD_SET;
            send_item(c, pool_data[p][k], k + 1 == pool_len[p], 4'($urandom));
        end
    endtask

    task automatic send_overflow(logic [1:0] cmd, int n);
        t_rsp tr;
        tr = '0;
        tr.last = 1'b1;
        tr.err = 1'b1;
        for (int k = 0; k < n - 1; k++) send_item(cmd, 8'($urandom), 1'b0, 4'd0);
        send_item(cmd, 8'($urandom), 1'b1, 4'd0, 1, tr);
    endtask

    function automatic void add_row(logic [1:0] c, logic [7:0] d, logic l, logic [3:0] i,
                                    logic t = 0, logic h = 0, logic [3:0] p = 0,
                                    logic e = 0);
        t_row rw;
        rw = '{cmd: c, data: d, last: l, idx: i, typed: t, hit: h, pos: p, err: e};
        dir_tab.push_back(rw);
    endfunction

    // response side
    initial begin
        int g;
        rsp.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            g = calm ? 0 : $urandom_range(0, 13);
            if (g > 0) begin
                rsp.ready = 1'b0;
                repeat (g) @(negedge i_clk);
            end
            rsp.ready = 1'b1;
            do @(posedge i_clk); while (!rsp.valid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            got = '{rsp.hit, rsp.hit_position, rsp.block_length, rsp.out_byte,
                    rsp.last_out, rsp.error};
            if (pending_rsp.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected item: %p", got);
            end else begin
                want = pending_rsp.pop_front();
                if (got !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) $display("mismatch: exp %p got %p", want, got);
                end
            end
        end
    end

    initial begin
        #60ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        t_row rw;
        t_rsp tr;
        int p;
        int w;
        req.valid = 1'b0;
        req.command = mtmbc_pkg::CMD_LOOKUP;
        req.data_byte = '0;
        req.last_byte = 1'b0;
        req.entry_index = '0;
        for (int i = 0; i < NENT; i++) order_q[i] = 4'(i);
        n_valid = 0;
        stream_len = 0;
        for (int i = 0; i < 24; i++) begin
            pool_len[i] = (i == 3 || i == 17) ? MAXB : $urandom_range(1, 4);
            for (int k = 0; k < MAXB; k++) pool_data[i][k] = 8'($urandom);
        end

        add_row(mtmbc_pkg::CMD_GET,    8'h00, 1, 4'd0,  1, 0, 4'd0, 1);
        add_row(mtmbc_pkg::CMD_LOOKUP, 8'h00, 1, 4'd0,  1, 0, 4'd0, 0);
        add_row(mtmbc_pkg::CMD_LOOKUP, 8'h00, 1, 4'd15, 1, 1, 4'd0, 0);
        add_row(mtmbc_pkg::CMD_SET,    8'hff, 1, 4'd0);
        add_row(mtmbc_pkg::CMD_GET,    8'h00, 0, 4'd15, 1, 0, 4'd0, 1);
        add_row(mtmbc_pkg::CMD_GET,    8'h00, 0, 4'd1);
        add_row(CMD_NONE,              8'hff, 1, 4'd15);
        add_row(mtmbc_pkg::CMD_LOOKUP, 8'haa, 0, 4'd0);
        add_row(mtmbc_pkg::CMD_SET,    8'h55, 1, 4'd0);
        add_row(mtmbc_pkg::CMD_SET,    8'haa, 0, 4'd0);
        add_row(mtmbc_pkg::CMD_LOOKUP, 8'h55, 1, 4'd0);
        add_row(mtmbc_pkg::CMD_LOOKUP, 8'hff, 1, 4'd0);
        add_row(mtmbc_pkg::CMD_GET,    8'h00, 1, 4'd2);
        add_row(mtmbc_pkg::CMD_GET,    8'h00, 1, 4'd0);
        add_row(mtmbc_pkg::CMD_LOOKUP, 8'h01, 0, 4'd0);
        add_row(mtmbc_pkg::CMD_LOOKUP, 8'h02, 1, 4'd0);
        add_row(mtmbc_pkg::CMD_GET,    8'h00, 0, 4'd3);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[i]) begin
            rw = dir_tab[i];
            tr = '0;
            tr.hit = rw.hit;
            tr.pos = rw.pos;
            tr.last = 1'b1;
            tr.err = rw.err;
            send_item(rw.cmd, rw.data, rw.last, rw.idx, rw.typed, tr);
        end
        send_overflow(mtmbc_pkg::CMD_LOOKUP, MAXB + 1);
        send_overflow(mtmbc_pkg::CMD_SET, MAXB + 2);

        // hold the sender until every expected item has drained
        while (pending_rsp.size() != 0) @(negedge i_clk);

        while (n_sent < 330) begin
            if (n_sent > 300 && n_sent < 320) calm = 1;
            else calm = 0;
            w = $urandom_range(0, 99);
            p = (pool_len[3] == MAXB && $urandom_range(0, 19) != 0)
                ? $urandom_range(0, 23) : $urandom_range(0, 23);
            if ((p == 3 || p == 17) && $urandom_range(0, 3) != 0) p = 0;
            if (w < 45) send_block(mtmbc_pkg::CMD_LOOKUP, p);
            else if (w < 60) send_block(mtmbc_pkg::CMD_SET, p);
            else if (w < 92) send_item(mtmbc_pkg::CMD_GET, 8'($urandom), 1'($urandom),
                                       4'($urandom_range(0, 15)));
            else if (w < 97) send_item(CMD_NONE, 8'($urandom), 1'($urandom), 4'($urandom));
            else if (w < 98) send_overflow(w[0] ? mtmbc_pkg::CMD_SET : mtmbc_pkg::CMD_LOOKUP,
                                           MAXB + 1);
            else begin
                while (pending_rsp.size() != 0) @(negedge i_clk);
                repeat (2500) @(negedge i_clk);
            end
        end

        while (pending_rsp.size() != 0) @(negedge i_clk);
        repeat (2500) @(negedge i_clk);
        if (n_mismatch == 0 && pending_rsp.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
